[rtl/core/ezt_pkg.sv]
package ezt_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int Q30_W            = 34;
    localparam int ATAN_DEPTH       = 24;
    localparam int FIFO_DEPTH       = 4;

    localparam logic signed [Q30_W-1:0] Q30_HALF_PI = 34'sh06487ED51;
    localparam logic signed [Q30_W-1:0] Q30_PI      = 34'sh0C90FDAA2;
    localparam logic signed [Q30_W-1:0] Q30_GAIN    = 34'sh026DD3B6A;
    localparam logic signed [15:0]      ONE_Q14     = 16'sd16384;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic signed [31:0]           shift_x;
        logic signed [31:0]           shift_y;
        logic signed [31:0]           shift_z;
    } ezt_in_t;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } ezt_out_t;

    // front-end product of angle classification
    typedef struct packed {
        logic signed [Q30_W-1:0] z_roll;
        logic signed [Q30_W-1:0] z_pitch;
        logic signed [Q30_W-1:0] z_yaw;
        logic [2:0]              flip;
        logic signed [31:0]      shift_x;
        logic signed [31:0]      shift_y;
        logic signed [31:0]      shift_z;
    } ezt_job_t;

    function automatic logic signed [Q30_W-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;
            2: v = 32'h0FADBAFC;   3: v = 32'h07F56EA6;
            4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;
            8: v = 32'h003FFFEA;   9: v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;  13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;  15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;  19: v = 32'h000007FF;
            20: v = 32'h000003FF;  21: v = 32'h000001FF;
            22: v = 32'h000000FF;  23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

    // (a*b + 2^29) >> 30, operands fit in 34 bits
    function automatic logic signed [Q30_W-1:0] mul_q30(
        input logic signed [Q30_W-1:0] a,
        input logic signed [Q30_W-1:0] b
    );
        logic signed [2*Q30_W-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return p[30 +: Q30_W];
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [Q30_W-1:0] v);
        logic signed [Q30_W:0] r;
        r = ($signed({v[Q30_W-1], v}) + (35'sd1 <<< 15)) >>> 16;
        if (r > 35'sd16384)
            return ONE_Q14;
        else if (r < -35'sd16384)
            return -ONE_Q14;
        else
            return r[15:0];
    endfunction

endpackage

[rtl/core/ezt_front.sv]
module ezt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ezt_pkg::ezt_in_t  in_item,
    output logic              job_valid,
    output ezt_pkg::ezt_job_t job
);
    import ezt_pkg::*;

    localparam int SHIFT = 33 - ANGLE_BITS;

    logic              job_valid_reg;
    ezt_job_t          job_reg;
    ezt_job_t          job_next;
    logic signed [Q30_W-1:0] zr;
    logic signed [Q30_W-1:0] zp;
    logic signed [Q30_W-1:0] zy;
    logic signed [Q30_W-1:0] rr;
    logic signed [Q30_W-1:0] rp;
    logic signed [Q30_W-1:0] ry;
    logic fr;
    logic fp;
    logic fy;

    assign zr = Q30_W'(in_item.roll_angle) <<< SHIFT;
    assign zp = Q30_W'(in_item.pitch_angle) <<< SHIFT;
    assign zy = Q30_W'(in_item.yaw_angle) <<< SHIFT;

    always_comb
    begin
        fr = (zr > Q30_HALF_PI) || (zr < -Q30_HALF_PI);
        fp = (zp > Q30_HALF_PI) || (zp < -Q30_HALF_PI);
        fy = (zy > Q30_HALF_PI) || (zy < -Q30_HALF_PI);
        rr = fr ? ((zr > 0) ? zr - Q30_PI : zr + Q30_PI) : zr;
        rp = fp ? ((zp > 0) ? zp - Q30_PI : zp + Q30_PI) : zp;
        ry = fy ? ((zy > 0) ? zy - Q30_PI : zy + Q30_PI) : zy;
        job_next.z_roll  = rr;
        job_next.z_pitch = rp;
        job_next.z_yaw   = ry;
        job_next.flip    = {fy, fp, fr};
        job_next.shift_x = in_item.shift_x;
        job_next.shift_y = in_item.shift_y;
        job_next.shift_z = in_item.shift_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else
            job_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;
endmodule

[rtl/core/ezt_queue.sv]
module ezt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ezt_pkg::ezt_job_t push_data,
    output logic              pop_valid,
    output ezt_pkg::ezt_job_t pop_data,
    output logic              full
);
    import ezt_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    ezt_job_t         mem [FIFO_DEPTH];
    logic [AW-1:0]    wr_reg;
    logic [AW-1:0]    rd_reg;
    logic [AW:0]      cnt_reg;
    logic             pop;

    // back end never stalls, so drain whenever something is queued
    assign pop       = cnt_reg != '0;
    assign pop_valid = pop;
    assign pop_data  = mem[rd_reg];
    assign full      = cnt_reg == (AW+1)'(FIFO_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end
endmodule

[rtl/core/ezt_back.sv]
module ezt_back #(
    parameter int CORDIC_STEPS = ezt_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  ezt_pkg::ezt_job_t job,
    output logic              done,
    output ezt_pkg::ezt_out_t result
);
    import ezt_pkg::*;

    localparam int N = CORDIC_STEPS;

    typedef struct packed {
        logic signed [Q30_W-1:0] x;
        logic signed [Q30_W-1:0] y;
        logic signed [Q30_W-1:0] z;
    } cs_t;

    typedef struct packed {
        cs_t [2:0]          c;
        logic [2:0]         flip;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } stage_t;

    stage_t st_in;
    logic   v_in;

    always_comb
    begin
        st_in.flip    = job.flip;
        st_in.shift_x = job.shift_x;
        st_in.shift_y = job.shift_y;
        st_in.shift_z = job.shift_z;
        st_in.c[0]    = '{x: Q30_GAIN, y: '0, z: job.z_roll};
        st_in.c[1]    = '{x: Q30_GAIN, y: '0, z: job.z_pitch};
        st_in.c[2]    = '{x: Q30_GAIN, y: '0, z: job.z_yaw};
        v_in          = job_valid;
    end

    // one cordic iteration per stage, three angles in parallel
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        stage_t cur;
        logic   cur_v;
        stage_t nx;
        stage_t s_reg;
        logic   v_reg;

        if (i == 0)
        begin : g_head
            assign cur   = st_in;
            assign cur_v = v_in;
        end
        else
        begin : g_link
            assign cur   = g_stage[i-1].s_reg;
            assign cur_v = g_stage[i-1].v_reg;
        end

        always_comb
        begin
            nx = cur;
            for (int k = 0; k < 3; k++)
            begin
                if (cur.c[k].z >= 0)
                begin
                    nx.c[k].x = cur.c[k].x - (cur.c[k].y >>> i);
                    nx.c[k].y = cur.c[k].y + (cur.c[k].x >>> i);
                    nx.c[k].z = cur.c[k].z - atan_q30(i);
                end
                else
                begin
                    nx.c[k].x = cur.c[k].x + (cur.c[k].y >>> i);
                    nx.c[k].y = cur.c[k].y - (cur.c[k].x >>> i);
                    nx.c[k].z = cur.c[k].z + atan_q30(i);
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else
                v_reg <= cur_v;
        end
        always_ff @(posedge clk)
        begin
            s_reg <= nx;
        end
    end

    stage_t st_out;
    logic   v_out;

    assign st_out = g_stage[N-1].s_reg;
    assign v_out  = g_stage[N-1].v_reg;

    // product stages: p1 singles and two-factor products, p2 triple products and Q14 entries
    logic signed [Q30_W-1:0] sx, cx, sy, cy, sz, cz;
    always_comb
    begin
        cx = st_out.flip[0] ? -st_out.c[0].x : st_out.c[0].x;
        sx = st_out.flip[0] ? -st_out.c[0].y : st_out.c[0].y;
        cy = st_out.flip[1] ? -st_out.c[1].x : st_out.c[1].x;
        sy = st_out.flip[1] ? -st_out.c[1].y : st_out.c[1].y;
        cz = st_out.flip[2] ? -st_out.c[2].x : st_out.c[2].x;
        sz = st_out.flip[2] ? -st_out.c[2].y : st_out.c[2].y;
    end

    logic signed [Q30_W-1:0] p_czsy_reg, p_szsy_reg, p_sx_reg, p_cx_reg, p_sy_reg;
    logic signed [Q30_W-1:0] p_czcy_reg, p_szcx_reg, p_szsx_reg, p_szcy_reg;
    logic signed [Q30_W-1:0] p_czcx_reg, p_czsx_reg, p_cysx_reg, p_cycx_reg;
    logic signed [31:0]      p_x_reg, p_y_reg, p_z_reg;
    logic                    p_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else
            p_v_reg <= v_out;
    end

    always_ff @(posedge clk)
    begin
        p_czsy_reg <= mul_q30(cz, sy);
        p_szsy_reg <= mul_q30(sz, sy);
        p_czcy_reg <= mul_q30(cz, cy);
        p_szcx_reg <= mul_q30(sz, cx);
        p_szsx_reg <= mul_q30(sz, sx);
        p_szcy_reg <= mul_q30(sz, cy);
        p_czcx_reg <= mul_q30(cz, cx);
        p_czsx_reg <= mul_q30(cz, sx);
        p_cysx_reg <= mul_q30(cy, sx);
        p_cycx_reg <= mul_q30(cy, cx);
        p_sx_reg   <= sx;
        p_cx_reg   <= cx;
        p_sy_reg   <= sy;
        p_x_reg    <= st_out.shift_x;
        p_y_reg    <= st_out.shift_y;
        p_z_reg    <= st_out.shift_z;
    end

    ezt_out_t res_reg;
    logic     done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= p_v_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg.rot_00 <= to_q14(p_czcy_reg);
        res_reg.rot_01 <= to_q14(mul_q30(p_czsy_reg, p_sx_reg) - p_szcx_reg);
        res_reg.rot_02 <= to_q14(mul_q30(p_czsy_reg, p_cx_reg) + p_szsx_reg);
        res_reg.rot_10 <= to_q14(p_szcy_reg);
        res_reg.rot_11 <= to_q14(mul_q30(p_szsy_reg, p_sx_reg) + p_czcx_reg);
        res_reg.rot_12 <= to_q14(mul_q30(p_szsy_reg, p_cx_reg) - p_czsx_reg);
        res_reg.rot_20 <= to_q14(-p_sy_reg);
        res_reg.rot_21 <= to_q14(p_cysx_reg);
        res_reg.rot_22 <= to_q14(p_cycx_reg);
        res_reg.out_x  <= p_x_reg;
        res_reg.out_y  <= p_y_reg;
        res_reg.out_z  <= p_z_reg;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

[rtl/core/euler_zyx_to_transform.sv]
// ZYX Euler angles to the upper three rows of a homogeneous transform. A pose is
// taken on any clock edge with start high and busy low, one per cycle, and its
// result is on result with done high for a single cycle once it has passed the
// front register, queue slot, pipelined CORDIC (one stage per step) and two
// multiplier stages. The receiver cannot stall; busy only rises if the
// internal queue fills, which it does not in use.
module euler_zyx_to_transform #(
    parameter int CORDIC_STEPS = ezt_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ezt_pkg::ezt_in_t  operand,
    output logic              done,
    output ezt_pkg::ezt_out_t result
);
    import ezt_pkg::*;

    logic     acc;
    logic     job_valid;
    ezt_job_t job;
    logic     q_valid;
    ezt_job_t q_data;
    logic     full;

    assign acc = start && !busy;

    ezt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_item(operand),
        .job_valid(job_valid), .job(job)
    );

    ezt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(job_valid), .push_data(job),
        .pop_valid(q_valid), .pop_data(q_data), .full(full)
    );

    ezt_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(q_data),
        .done(done), .result(result)
    );

    assign busy = full;
endmodule

[rtl/core/ezt_checker.sv]
module ezt_checker #(
    parameter int LATENCY = ezt_pkg::CORDIC_STEPS_DEF + 4
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input ezt_pkg::ezt_out_t result,
    input logic              done
);
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("transaction result missing");
    a_rot20_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.rot_20 <= 16'sd16384) && (result.rot_20 >= -16'sd16384))
        else $error("rot_20 out of range");
    a_rot00_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.rot_00 <= 16'sd16384) && (result.rot_00 >= -16'sd16384))
        else $error("rot_00 out of range");
endmodule

bind euler_zyx_to_transform ezt_checker #(.LATENCY(CORDIC_STEPS + 4)) u_ezt_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .result(result), .done(done)
);

[dv/euler_zyx_checker.sv]
module euler_zyx_checker
    import ezt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  ezt_in_t  operand,
    input  logic     done,
    input  ezt_out_t result,
    output int       fail_count,
    output int       pending,
    output int       matched
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_W = 16;
    localparam int STEPS   = 16;

    localparam longint HALF_PI = 64'sh6487ED51;
    localparam longint PI_Q30  = 64'shC90FDAA2;
    localparam longint GAIN    = 64'sh26DD3B6A;

    longint arctan_tab [24] = '{
        64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
        64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
        64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
        64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF,
        64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
        64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F
    };

    ezt_out_t pose_queue [$];
    int       mismatches;

    assign pending    = pose_queue.size();
    assign fail_count = mismatches;

    // arithmetic shift of a 64-bit signed value is a floor
    function automatic void angle_sin_cos(input logic signed [15:0] raw,
                                          output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'(raw) * (64'sd1 <<< (33 - ANGLE_W));
        flip = 0;
        x = GAIN;
        y = 0;
        if (z > HALF_PI)
        begin
            z = z - PI_Q30;
            flip = 1;
        end
        else if (z < -HALF_PI)
        begin
            z = z + PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_tab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_tab[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] entry_q14(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 15)) >>> 16;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic ezt_out_t transform_of(input ezt_in_t p);
        ezt_out_t t;
        longint   sx, cx, sy, cy, sz, cz, czsy, szsy;
        angle_sin_cos(p.roll_angle, sx, cx);
        angle_sin_cos(p.pitch_angle, sy, cy);
        angle_sin_cos(p.yaw_angle, sz, cz);
        czsy = q30_product(cz, sy);
        szsy = q30_product(sz, sy);
        t.rot_00 = entry_q14(q30_product(cz, cy));
        t.rot_01 = entry_q14(q30_product(czsy, sx) - q30_product(sz, cx));
        t.rot_02 = entry_q14(q30_product(czsy, cx) + q30_product(sz, sx));
        t.rot_10 = entry_q14(q30_product(sz, cy));
        t.rot_11 = entry_q14(q30_product(szsy, sx) + q30_product(cz, cx));
        t.rot_12 = entry_q14(q30_product(szsy, cx) - q30_product(cz, sx));
        t.rot_20 = entry_q14(-sy);
        t.rot_21 = entry_q14(q30_product(cy, sx));
        t.rot_22 = entry_q14(q30_product(cy, cx));
        t.out_x  = p.shift_x;
        t.out_y  = p.shift_y;
        t.out_z  = p.shift_z;
        return t;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d actual %0d at %0t", name, want, got, $time);
        end
    endtask

    initial
    begin
        mismatches = 0;
        matched = 0;
    end

    always @(posedge clk)
    begin
        ezt_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pose_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction at %0t", $time);
                end
                else
                begin
                    want = pose_queue.pop_front();
                    compare_field("rot_00", want.rot_00, result.rot_00);
                    compare_field("rot_01", want.rot_01, result.rot_01);
                    compare_field("rot_02", want.rot_02, result.rot_02);
                    compare_field("rot_10", want.rot_10, result.rot_10);
                    compare_field("rot_11", want.rot_11, result.rot_11);
                    compare_field("rot_12", want.rot_12, result.rot_12);
                    compare_field("rot_20", want.rot_20, result.rot_20);
                    compare_field("rot_21", want.rot_21, result.rot_21);
                    compare_field("rot_22", want.rot_22, result.rot_22);
                    compare_field("out_x", want.out_x, result.out_x);
                    compare_field("out_y", want.out_y, result.out_y);
                    compare_field("out_z", want.out_z, result.out_z);
                    matched++;
                end
            end
            if (start && !busy)
                pose_queue.push_back(transform_of(operand));
        end
    end
endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ezt_pkg::*;

    localparam int LATENCY  = CORDIC_STEPS_DEF + 4;
    localparam int ANGLE_MAX = 25736;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ezt_in_t  operand;
    logic     done;
    ezt_out_t result;
    int       fail_count;
    int       pending;
    int       matched;
    int       idle_pct;
    int       sent;

    euler_zyx_to_transform DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operand(operand), .done(done), .result(result)
    );

    euler_zyx_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .operand(operand),
        .done(done), .result(result), .fail_count(fail_count),
        .pending(pending), .matched(matched)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    function automatic logic signed [15:0] any_angle();
        return 16'(int'($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
    endfunction

    // holds start until the transaction is taken, random gaps before it
    task automatic send_pose(input ezt_in_t p);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        operand <= p;
        // busy only moves on rising edges, so its value here holds at the next one
        while (busy)
            @(negedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_angles(input int r, input int p, input int y);
        ezt_in_t v;
        v.roll_angle  = 16'(r);
        v.pitch_angle = 16'(p);
        v.yaw_angle   = 16'(y);
        v.shift_x = $urandom();
        v.shift_y = $urandom();
        v.shift_z = $urandom();
        send_pose(v);
    endtask

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        ezt_in_t v;
        int      corner [7];
        int      guard;
        corner = '{-ANGLE_MAX, -12868, -1, 0, 1, 12868, ANGLE_MAX};
        start = 0;
        operand = '0;
        rst_n = 0;
        sent = 0;
        idle_pct = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // extremes, near +-pi/2 and zero
        for (int i = 0; i < 7; i++)
            send_angles(corner[i], corner[(i + 3) % 7], corner[6 - i]);
        send_angles(12867, 12869, -12869);
        send_angles(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
        send_angles(-ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX);
        v = '0;
        v.shift_x = 32'h80000000; v.shift_y = 32'h7FFFFFFF; v.shift_z = 32'hFFFFFFFF;
        send_pose(v);
        v.shift_x = 32'h7FFFFFFF; v.shift_y = 32'h80000000; v.shift_z = 32'h00000000;
        send_pose(v);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 19 : (phase == 1) ? 74 : 0;
            for (int n = 0; n < 133; n++)
            begin
                v.roll_angle  = any_angle();
                v.pitch_angle = any_angle();
                v.yaw_angle   = any_angle();
                v.shift_x = $urandom();
                v.shift_y = $urandom();
                v.shift_z = $urandom();
                send_pose(v);
            end
        end
        start <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 10000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 10) @(negedge clk);

        $display("poses sent %0d, transforms checked %0d", sent, matched);
        $display("angles spanned +-pi with corner and pass-through extremes, three gap mixes");
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
